### hw/rtl/svp_pkg.sv
// ----------------------------------------------------------------------------
// svp_pkg
// Shared types and codes of the sample voice player.
// ----------------------------------------------------------------------------
package svp_pkg;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_EVENT = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    localparam logic [1:0] MODE_TRIGGER = 2'd0;
    localparam logic [1:0] MODE_GATE    = 2'd1;
    localparam logic [1:0] MODE_ONESHOT = 2'd2;

    localparam logic [2:0] CFG_PLAY_MODE     = 3'd0;
    localparam logic [2:0] CFG_REVERSE       = 3'd1;
    localparam logic [2:0] CFG_LOOP_ENABLE   = 3'd2;
    localparam logic [2:0] CFG_SPEED         = 3'd3;
    localparam logic [2:0] CFG_RATE_RATIO    = 3'd4;
    localparam logic [2:0] CFG_VOLUME        = 3'd5;
    localparam logic [2:0] CFG_SAMPLE_LENGTH = 3'd6;
    localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ZOUT,
        ST_MOD,
        ST_DIV,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_CAP,
        ST_MUL1,
        ST_MUL2,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       accept;
        logic       mod_start;
        logic       div_step;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_en;
        logic [1:0] cap_sel;
        logic       mul1;
        logic       mul2;
        logic       out_load;
        logic       out_zero;
    } cmd_t;

    typedef struct packed {
        logic is_playing;
        logic need_div;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

### hw/rtl/svp_ctrl.sv
// ----------------------------------------------------------------------------
// svp_ctrl
// Sequencer of the voice: accepts items, steps reads and arithmetic.
// ----------------------------------------------------------------------------
module svp_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic [1:0]      s_func,
    output logic            s_ready,
    input  svp_pkg::status_t st,
    output svp_pkg::cmd_t    cmd
);
    import svp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (s_func == FUNC_TICK) begin
                        state_next = st.is_playing ? ST_MOD : ST_ZOUT;
                    end
                end
            end
            ST_ZOUT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_zero = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_MOD: begin
                cmd.mod_start = 1'b1;
                state_next    = st.need_div ? ST_DIV : ST_RD0;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (st.div_last) begin
                    state_next = ST_RD0;
                end
            end
            ST_RD0: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = 2'd0;
                state_next = ST_RD1;
            end
            ST_RD1: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = 2'd1;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = 2'd0;
                state_next  = ST_RD2;
            end
            ST_RD2: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = 2'd2;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = 2'd1;
                state_next  = ST_RD3;
            end
            ST_RD3: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = 2'd3;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = 2'd2;
                state_next  = ST_CAP;
            end
            ST_CAP: begin
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = 2'd3;
                state_next  = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/svp_dpath.sv
// ----------------------------------------------------------------------------
// svp_dpath
// Voice datapath: config registers, sample memory, position, interpolation,
// volume scaling and the output register.
// ----------------------------------------------------------------------------
module svp_dpath #(
    parameter int MAX_FRAMES          = 65536,
    parameter int OUT_CHANNELS        = 2,
    parameter int MAX_SAMPLE_CHANNELS = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  svp_pkg::cmd_t      cmd,
    output svp_pkg::status_t   st,
    input  logic [1:0]         s_func,
    input  logic               s_pressed,
    input  logic               s_from_midi,
    input  logic [16:0]        s_write_address,
    input  logic signed [15:0] s_write_data,
    input  logic               cfg_valid,
    input  logic [2:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_left_sample,
    output logic signed [15:0] m_right_sample,
    output logic               m_playing,
    output logic [15:0]        m_frame_position
);
    import svp_pkg::*;

    localparam int IW        = $clog2(MAX_FRAMES);
    localparam int LW        = $clog2(MAX_FRAMES + 1);
    localparam int PW        = IW + 16;
    localparam int CW        = $clog2(MAX_SAMPLE_CHANNELS + 1);
    localparam int MEM_DEPTH = MAX_FRAMES * MAX_SAMPLE_CHANNELS;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int SW        = ((PW > 24) ? PW : 24) + 2;
    localparam int CNTW      = $clog2(IW + 1);

    function automatic logic signed [15:0] sat16(input logic signed [35:0] x);
        logic signed [35:0] y;
        y = x >>> 15;
        if (y > 36'sd32767) begin
            return 16'sh7FFF;
        end else if (y < -36'sd32768) begin
            return -16'sh8000;
        end
        return y[15:0];
    endfunction

    // configuration
    logic [1:0]  play_mode_reg;
    logic        reverse_reg;
    logic [15:0] speed_reg, ratio_reg, volume_reg;
    logic [16:0] length_reg;
    logic [1:0]  chans_reg;

    // voice state
    logic [PW-1:0] pos_reg, pos_next;
    logic          playing_reg, playing_next;
    logic          loop_reg, loop_next;
    logic          last_press_reg;

    logic signed [15:0] mem [MEM_DEPTH];
    logic signed [15:0] rd_data_reg;
    logic signed [15:0] smp_reg [4];

    logic [IW-1:0]   q_reg;
    logic [LW-1:0]   rem_reg, rem_next;
    logic [IW-1:0]   dvd_reg;
    logic [CNTW-1:0] cnt_reg;

    logic signed [16:0] v0_reg, v1_reg;
    logic [17:0]        vol2_reg;
    logic [23:0]        step_reg;
    logic signed [15:0] o0_reg, o1_reg;

    logic               m_valid_reg;
    logic signed [15:0] m_left_reg, m_right_reg;
    logic               m_playing_reg;
    logic [15:0]        m_pos_reg;

    logic [LW-1:0] len;
    logic [CW-1:0] cc;
    logic [IW-1:0] ip, nq, frame;
    logic [15:0]   frac;
    logic [PW-1:0] rewind_pos;
    logic [AW-1:0] rd_addr;
    logic          stride;
    logic [LW:0]   div_t;

    logic          ev_apply, ev_set, ev_force, ev_rewind;
    logic signed [SW-1:0] sp, sstep, np, endp, lenm1;

    always_comb begin
        if (length_reg == 17'd0) begin
            len = LW'(1);
        end else if (32'(length_reg) > MAX_FRAMES) begin
            len = LW'(MAX_FRAMES);
        end else begin
            len = LW'(length_reg);
        end
        if (chans_reg == 2'd0) begin
            cc = CW'(1);
        end else if (32'(chans_reg) > MAX_SAMPLE_CHANNELS) begin
            cc = CW'(MAX_SAMPLE_CHANNELS);
        end else begin
            cc = CW'(chans_reg);
        end
    end

    assign ip         = pos_reg[PW-1:16];
    assign frac       = pos_reg[15:0];
    assign rewind_pos = reverse_reg ? {IW'(len - LW'(1)), 16'h0000} : '0;
    assign nq         = ((LW + 1)'(q_reg) + (LW + 1)'(1) == (LW + 1)'(len)) ? '0
                        : q_reg + IW'(1);

    assign frame   = cmd.rd_sel[0] ? nq : q_reg;
    assign stride  = cmd.rd_sel[1] && (cc > CW'(1));
    assign rd_addr = AW'(frame) * AW'(cc) + AW'(stride);

    assign div_t    = {rem_reg, dvd_reg[IW-1]};
    assign rem_next = (div_t >= (LW + 1)'(len)) ? LW'(div_t - (LW + 1)'(len)) : LW'(div_t);

    assign st.is_playing = playing_reg;
    assign st.need_div   = 32'(ip) >= 32'(len);
    assign st.div_last   = cnt_reg == CNTW'(1);
    assign st.out_free   = !m_valid_reg || m_ready;

    // press events
    always_comb begin
        ev_apply = 1'b0;
        ev_set   = 1'b0;
        ev_force = 1'b0;
        if (s_pressed != last_press_reg) begin
            case (play_mode_reg)
                MODE_TRIGGER: begin
                    if (s_from_midi) begin
                        ev_apply = 1'b1;
                        ev_set   = s_pressed;
                    end else if (s_pressed) begin
                        ev_apply = 1'b1;
                        ev_set   = !playing_reg;
                    end
                end
                MODE_GATE: begin
                    ev_apply = 1'b1;
                    ev_set   = s_pressed;
                end
                MODE_ONESHOT: begin
                    if (s_pressed) begin
                        ev_apply = 1'b1;
                        ev_set   = 1'b1;
                        ev_force = 1'b1;
                    end
                end
                default: begin
                    ev_apply = 1'b0;
                end
            endcase
        end
        ev_rewind = ev_apply && ((ev_set && !playing_reg) || ev_force);
    end

    // position advance
    always_comb begin
        sp           = SW'(pos_reg);
        sstep        = SW'(step_reg);
        endp         = SW'({len, 16'h0000});
        lenm1        = SW'({IW'(len - LW'(1)), 16'h0000});
        np           = sp;
        pos_next     = pos_reg;
        playing_next = playing_reg;
        loop_next    = loop_reg;
        if (cmd.accept && s_func == FUNC_EVENT && ev_apply) begin
            playing_next = ev_set;
            if (ev_force) begin
                loop_next = 1'b0;
            end
            if (ev_rewind) begin
                pos_next = rewind_pos;
            end
        end else if (cmd.out_load && !cmd.out_zero) begin
            if (!reverse_reg && step_reg != '0) begin
                np = sp + sstep;
                if (np >= endp) begin
                    if (loop_reg) begin
                        pos_next = PW'(np[15:0]);
                    end else begin
                        pos_next     = rewind_pos;
                        playing_next = 1'b0;
                    end
                end else begin
                    pos_next = PW'(np);
                end
            end else if (reverse_reg) begin
                np = sp - sstep;
                if (np < 0) begin
                    if (loop_reg) begin
                        np       = np + lenm1;
                        pos_next = (np < 0) ? '0 : PW'(np);
                    end else begin
                        pos_next     = rewind_pos;
                        playing_next = 1'b0;
                    end
                end else begin
                    pos_next = PW'(np);
                end
            end
        end
        if (cfg_valid && cfg_index == CFG_LOOP_ENABLE) begin
            loop_next = cfg_data[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            play_mode_reg  <= MODE_TRIGGER;
            reverse_reg    <= 1'b0;
            speed_reg      <= 16'd4096;
            ratio_reg      <= 16'd4096;
            volume_reg     <= 16'd32768;
            length_reg     <= 17'd65536;
            chans_reg      <= 2'd1;
            pos_reg        <= '0;
            playing_reg    <= 1'b0;
            loop_reg       <= 1'b0;
            last_press_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_PLAY_MODE:     play_mode_reg <= cfg_data[1:0];
                    CFG_REVERSE:       reverse_reg   <= cfg_data[0];
                    CFG_SPEED:         speed_reg     <= cfg_data[15:0];
                    CFG_RATE_RATIO:    ratio_reg     <= cfg_data[15:0];
                    CFG_VOLUME:        volume_reg    <= cfg_data[15:0];
                    CFG_SAMPLE_LENGTH: length_reg    <= cfg_data;
                    CFG_CHANNEL_COUNT: chans_reg     <= cfg_data[1:0];
                    default: ;
                endcase
            end
            pos_reg     <= pos_next;
            playing_reg <= playing_next;
            loop_reg    <= loop_next;
            if (cmd.accept && s_func == FUNC_EVENT && s_pressed != last_press_reg) begin
                last_press_reg <= s_pressed;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // sample memory
    always_ff @(posedge aclk) begin
        if (cmd.accept && s_func == FUNC_WRITE && 32'(s_write_address) < MEM_DEPTH) begin
            mem[AW'(s_write_address)] <= s_write_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // frame index, interpolation, scaling and the output register
    always_ff @(posedge aclk) begin
        if (cmd.mod_start) begin
            q_reg   <= ip;
            rem_reg <= '0;
            dvd_reg <= ip;
            cnt_reg <= CNTW'(IW);
        end
        if (cmd.div_step) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_reg << 1;
            cnt_reg <= cnt_reg - CNTW'(1);
            if (st.div_last) begin
                q_reg <= IW'(rem_next);
            end
        end
        if (cmd.cap_en) begin
            smp_reg[cmd.cap_sel] <= rd_data_reg;
        end
        if (cmd.mul1) begin
            v0_reg   <= 17'(smp_reg[0]) + 17'((34'(17'(smp_reg[1]) - 17'(smp_reg[0]))
                        * $signed({18'd0, frac})) >>> 16);
            v1_reg   <= 17'(smp_reg[2]) + 17'((34'(17'(smp_reg[3]) - 17'(smp_reg[2]))
                        * $signed({18'd0, frac})) >>> 16);
            vol2_reg <= 18'((32'(volume_reg) * 32'(volume_reg)) >> 15);
            step_reg <= 24'((32'(speed_reg) * 32'(ratio_reg)) >> 8);
        end
        if (cmd.mul2) begin
            o0_reg <= sat16(36'(v0_reg) * $signed({18'd0, vol2_reg}));
            o1_reg <= sat16(36'(v1_reg) * $signed({18'd0, vol2_reg}));
        end
        if (cmd.out_load) begin
            if (cmd.out_zero) begin
                m_left_reg    <= '0;
                m_right_reg   <= '0;
                m_playing_reg <= 1'b0;
                m_pos_reg     <= '0;
            end else begin
                m_left_reg    <= o0_reg;
                m_right_reg   <= (OUT_CHANNELS > 1) ? o1_reg : 16'sd0;
                m_playing_reg <= 1'b1;
                m_pos_reg     <= 16'(ip);
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_left_sample    = m_left_reg;
    assign m_right_sample   = m_right_reg;
    assign m_playing        = m_playing_reg;
    assign m_frame_position = m_pos_reg;

endmodule

### hw/rtl/sample_voice_player.sv
// ----------------------------------------------------------------------------
// sample_voice_player
// One sampler voice with linear interpolation and volume scaling.
// ----------------------------------------------------------------------------
// Input channel s_*: s_func selects an output tick, a press event or a write
// of one word into the sample memory. Events and writes give no item. Every
// tick gives one item on m_*. A tick on a stopped voice loads a zero item
// into the output register from state ZOUT once that register is free.
// A tick on a playing voice reads four memory words through one read port,
// one per cycle, then interpolates, scales and advances the position. If
// the read position lies at or beyond the current length, a bit-serial
// remainder first runs, one bit of the frame index per cycle (16 bits at
// the default size). One item is in work at a time. A finished item waits
// in the output register while the next item is taken; a tick that finishes
// while that register still holds an item and m_ready is low waits for it.
// cfg_*: register writes, always ready; write only while the voice is idle.
// Reset (aresetn low, synchronous) loads register defaults, stops the voice
// and rewinds it; the sample memory is not cleared.
// ----------------------------------------------------------------------------
module sample_voice_player #(
    parameter int MAX_FRAMES          = 65536,
    parameter int OUT_CHANNELS        = 2,
    parameter int MAX_SAMPLE_CHANNELS = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic               s_pressed,
    input  logic               s_from_midi,
    input  logic [16:0]        s_write_address,
    input  logic signed [15:0] s_write_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_left_sample,
    output logic signed [15:0] m_right_sample,
    output logic               m_playing,
    output logic [15:0]        m_frame_position,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [16:0]        cfg_data
);
    import svp_pkg::*;

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    svp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    svp_dpath #(
        .MAX_FRAMES          (MAX_FRAMES),
        .OUT_CHANNELS        (OUT_CHANNELS),
        .MAX_SAMPLE_CHANNELS (MAX_SAMPLE_CHANNELS)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .st               (st),
        .s_func           (s_func),
        .s_pressed        (s_pressed),
        .s_from_midi      (s_from_midi),
        .s_write_address  (s_write_address),
        .s_write_data     (s_write_data),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_sample    (m_left_sample),
        .m_right_sample   (m_right_sample),
        .m_playing        (m_playing),
        .m_frame_position (m_frame_position)
    );

endmodule

### hw/rtl/svp_checker.sv
// ----------------------------------------------------------------------------
// svp_checker
// Port-level checks of the sample voice player, bound to the top level.
// ----------------------------------------------------------------------------
module svp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_func,
    input logic               s_pressed,
    input logic               s_from_midi,
    input logic [16:0]        s_write_address,
    input logic signed [15:0] s_write_data,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_left_sample,
    input logic signed [15:0] m_right_sample,
    input logic               m_playing,
    input logic [15:0]        m_frame_position,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [2:0]         cfg_index,
    input logic [16:0]        cfg_data
);
    import svp_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_sample)
            && $stable(m_right_sample) && $stable(m_frame_position))
        else $error("result changed while stalled");

    a_stopped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_playing |-> m_left_sample == 16'sd0
            && m_right_sample == 16'sd0 && m_frame_position == 16'd0)
        else $error("stopped item not zero");

    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == FUNC_TICK |=> !s_ready)
        else $error("input taken while tick in work");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind sample_voice_player svp_checker u_svp_checker (.*);
